@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing under SYNTH.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/ssidip_pkg.sv @@
// ---------------------------------------------------------------------------
// ssidip_pkg
// Constants and types shared by the SSID and IP field extractor.
// ---------------------------------------------------------------------------
package ssidip_pkg;

  // Field widths.
  localparam int ByteW = 8;
  localparam int AddrW = 4;

  // Default capture lengths.
  localparam int SsidLenDef   = 10;
  localparam int IpPartLenDef = 16;

  // Characters recognized in the response text.
  localparam logic [ByteW-1:0] ChNul    = 8'h00;
  localparam logic [ByteW-1:0] ChColon  = 8'h3A;
  localparam logic [ByteW-1:0] ChQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChP      = 8'h50;
  localparam logic [ByteW-1:0] ChComma  = 8'h2C;
  localparam logic [ByteW-1:0] ChPeriod = 8'h2E;

  // Period counter saturation and part switch point.
  localparam logic [1:0] PeriodMax    = 2'd3;
  localparam logic [1:0] PeriodSwitch = 2'd2;

  // Input register contents handed to the extraction stage.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] rx_byte;
  } stage_t;

endpackage

@@ rtl/ssidip_rx_if.sv @@
// ---------------------------------------------------------------------------
// ssidip_rx_if
// Receive byte channel with valid/ready handshake.
// ---------------------------------------------------------------------------
interface ssidip_rx_if;
  logic                        valid;
  logic                        ready;
  logic [ssidip_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/ssidip_res_if.sv @@
// ---------------------------------------------------------------------------
// ssidip_res_if
// Result channel: forwarded byte and store write strobes.
// ---------------------------------------------------------------------------
interface ssidip_res_if;
  logic                        valid;
  logic                        ready;
  logic                        fwd_valid;
  logic [ssidip_pkg::ByteW-1:0] fwd_byte;
  logic                        ssid_we;
  logic [ssidip_pkg::AddrW-1:0] ssid_addr;
  logic                        ip1_we;
  logic [ssidip_pkg::AddrW-1:0] ip1_addr;
  logic                        ip2_we;
  logic [ssidip_pkg::AddrW-1:0] ip2_addr;

  modport source (output valid, output fwd_valid, output fwd_byte, output ssid_we,
                  output ssid_addr, output ip1_we, output ip1_addr, output ip2_we,
                  output ip2_addr, input ready);
  modport sink   (input valid, input fwd_valid, input fwd_byte, input ssid_we,
                  input ssid_addr, input ip1_we, input ip1_addr, input ip2_we,
                  input ip2_addr, output ready);
endinterface

@@ rtl/ssidip_in_stage.sv @@
// ---------------------------------------------------------------------------
// ssidip_in_stage
// Input register for received bytes; holds one byte until the next stage
// takes it.
// ---------------------------------------------------------------------------
module ssidip_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  ssidip_rx_if.sink          rx,
  input  logic               take_i,
  output ssidip_pkg::stage_t stage_o
);

  logic                         valid_q, valid_d;
  logic [ssidip_pkg::ByteW-1:0] byte_q, byte_d;

  // Ready whenever the register is empty or is being emptied this cycle.
  assign rx.ready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (rx.ready) begin
      valid_d = rx.valid;
      byte_d  = rx.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign stage_o.valid   = valid_q;
  assign stage_o.rx_byte = byte_q;

endmodule

@@ rtl/ssidip_extract.sv @@
// ---------------------------------------------------------------------------
// ssidip_extract
// Capture state, field detection and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssidip_extract #(
  parameter int SsidLen   = ssidip_pkg::SsidLenDef,
  parameter int IpPartLen = ssidip_pkg::IpPartLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssidip_pkg::stage_t stage_i,
  output logic               take_o,
  ssidip_res_if.source       res
);

  localparam int SsidCntW = $clog2(SsidLen + 1);
  localparam int IpCntW   = $clog2(IpPartLen + 1);
  localparam int ByteW    = ssidip_pkg::ByteW;
  localparam int AddrW    = ssidip_pkg::AddrW;

  // Capture state.
  logic [ByteW-1:0]    prev_q, prev_d;
  logic [ByteW-1:0]    pprev_q, pprev_d;
  logic                ssid_act_q, ssid_act_d;
  logic [SsidCntW-1:0] ssid_cnt_q, ssid_cnt_d;
  logic                ip_act_q, ip_act_d;
  logic [1:0]          period_q, period_d;
  logic                part1_q, part1_d;
  logic                part2_q, part2_d;
  logic [IpCntW-1:0]   ip1_cnt_q, ip1_cnt_d;
  logic [IpCntW-1:0]   ip2_cnt_q, ip2_cnt_d;

  // Result register.
  logic             out_valid_q;
  logic             fwd_valid_q, fwd_valid_d;
  logic [ByteW-1:0] fwd_byte_q, fwd_byte_d;
  logic             ssid_we_q, ssid_we_d;
  logic [AddrW-1:0] ssid_addr_q, ssid_addr_d;
  logic             ip1_we_q, ip1_we_d;
  logic [AddrW-1:0] ip1_addr_q, ip1_addr_d;
  logic             ip2_we_q, ip2_we_d;
  logic [AddrW-1:0] ip2_addr_q, ip2_addr_d;

  logic [ByteW-1:0] c;
  logic             nonzero;
  logic             is_quote;
  logic             wr_ssid, wr_ip1, wr_ip2;

  // A byte moves into the result register when that register is free or drained.
  assign take_o  = stage_i.valid && (!out_valid_q || res.ready);
  assign c       = stage_i.rx_byte;
  assign nonzero = (c != ssidip_pkg::ChNul);
  assign is_quote = (c == ssidip_pkg::ChQuote);

  // Write strobes from the state before this byte.
  assign wr_ssid = ssid_act_q && !is_quote;
  assign wr_ip1  = ip_act_q && part1_q && (ip1_cnt_q < IpPartLen);
  assign wr_ip2  = ip_act_q && part2_q && !is_quote && (ip2_cnt_q < IpPartLen);

  // Next capture state for a nonzero byte.
  always_comb begin
    ssid_cnt_d = ssid_cnt_q + SsidCntW'(wr_ssid);
    ssid_act_d = ssid_act_q && !(is_quote || (ssid_cnt_d >= SsidLen));
    if ((ssid_cnt_d < SsidLen) && (prev_q == ssidip_pkg::ChColon) && is_quote) begin
      ssid_act_d = 1'b1;
    end

    period_d  = period_q;
    part1_d   = part1_q;
    part2_d   = part2_q;
    ip_act_d  = ip_act_q;
    ip1_cnt_d = ip1_cnt_q + IpCntW'(wr_ip1);
    ip2_cnt_d = ip2_cnt_q + IpCntW'(wr_ip2);
    if (ip_act_q) begin
      if ((period_q != ssidip_pkg::PeriodMax) && (c == ssidip_pkg::ChPeriod)) begin
        period_d = period_q + 2'd1;
      end
      if (period_d == ssidip_pkg::PeriodSwitch) begin
        part1_d = 1'b0;
        part2_d = 1'b1;
      end
      if (is_quote) begin
        ip_act_d = 1'b0;
      end
    end
    // The IP start sequence only counts while part one is still empty.
    if ((ip1_cnt_d == '0) && (pprev_q == ssidip_pkg::ChP) &&
        (prev_q == ssidip_pkg::ChComma) && is_quote) begin
      part1_d  = 1'b1;
      ip_act_d = 1'b1;
    end

    pprev_d = prev_q;
    prev_d  = c;
  end

  // Result fields; a zero byte yields an all-zero result.
  always_comb begin
    fwd_valid_d = nonzero;
    fwd_byte_d  = c;
    ssid_we_d   = nonzero && wr_ssid;
    ip1_we_d    = nonzero && wr_ip1;
    ip2_we_d    = nonzero && wr_ip2;
    ssid_addr_d = ssid_we_d ? AddrW'(ssid_cnt_q) : '0;
    ip1_addr_d  = ip1_we_d ? AddrW'(ip1_cnt_q) : '0;
    ip2_addr_d  = ip2_we_d ? AddrW'(ip2_cnt_q) : '0;
  end

  // State registers; updated only by a nonzero byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      pprev_q    <= '0;
      ssid_act_q <= 1'b0;
      ssid_cnt_q <= '0;
      ip_act_q   <= 1'b0;
      period_q   <= '0;
      part1_q    <= 1'b0;
      part2_q    <= 1'b0;
      ip1_cnt_q  <= '0;
      ip2_cnt_q  <= '0;
    end else if (take_o && nonzero) begin
      prev_q     <= prev_d;
      pprev_q    <= pprev_d;
      ssid_act_q <= ssid_act_d;
      ssid_cnt_q <= ssid_cnt_d;
      ip_act_q   <= ip_act_d;
      period_q   <= period_d;
      part1_q    <= part1_d;
      part2_q    <= part2_d;
      ip1_cnt_q  <= ip1_cnt_d;
      ip2_cnt_q  <= ip2_cnt_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded on each transfer into the register.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      fwd_valid_q <= fwd_valid_d;
      fwd_byte_q  <= fwd_byte_d;
      ssid_we_q   <= ssid_we_d;
      ssid_addr_q <= ssid_addr_d;
      ip1_we_q    <= ip1_we_d;
      ip1_addr_q  <= ip1_addr_d;
      ip2_we_q    <= ip2_we_d;
      ip2_addr_q  <= ip2_addr_d;
    end
  end

  assign res.valid     = out_valid_q;
  assign res.fwd_valid = fwd_valid_q;
  assign res.fwd_byte  = fwd_byte_q;
  assign res.ssid_we   = ssid_we_q;
  assign res.ssid_addr = ssid_addr_q;
  assign res.ip1_we    = ip1_we_q;
  assign res.ip1_addr  = ip1_addr_q;
  assign res.ip2_we    = ip2_we_q;
  assign res.ip2_addr  = ip2_addr_q;

  // Counters never pass their capture lengths.
  `ASSERT_CLK(a_ssid_cnt_bound, clk_i, rst_ni, ssid_cnt_q <= SsidCntW'(SsidLen))
  `ASSERT_CLK(a_ip1_cnt_bound, clk_i, rst_ni, ip1_cnt_q <= IpCntW'(IpPartLen))
  `ASSERT_CLK(a_ip2_cnt_bound, clk_i, rst_ni, ip2_cnt_q <= IpCntW'(IpPartLen))
  // A result for a zero byte carries no write.
  `ASSERT_IMPL(a_zero_no_write, clk_i, rst_ni, out_valid_q && !fwd_valid_q, !ssid_we_q && !ip1_we_q && !ip2_we_q)
  // The SSID count only moves on a transfer that writes the SSID store.
  `ASSERT_IMPL(a_ssid_cnt_moves, clk_i, rst_ni, ssid_cnt_q != $past(ssid_cnt_q), $past(take_o && nonzero && wr_ssid))

endmodule

@@ rtl/ssid_ip_field_extractor.sv @@
// ---------------------------------------------------------------------------
// ssid_ip_field_extractor
// Watches response text one byte at a time, forwards nonzero bytes and
// raises SSID and IP store writes with their positions.
// ---------------------------------------------------------------------------
//  channel | direction | payload
//  --------+-----------+---------------------------------------------------
//  rx      | in        | rx_byte
//  res     | out       | fwd_valid, fwd_byte, ssid/ip1/ip2 write and address
//
// One byte per cycle sustained while results are taken; each byte waits in the
// input register and leaves from the result register on the next transfer.
// The result is set by combinational flag and counter logic per byte.
// Reset clears the byte history, capture flags and counters at once.
// A stalled result holds; the input register keeps accepting while the
// result register can be drained in the same cycle.
// ---------------------------------------------------------------------------
module ssid_ip_field_extractor #(
  parameter int SsidLen   = ssidip_pkg::SsidLenDef,
  parameter int IpPartLen = ssidip_pkg::IpPartLenDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ssidip_rx_if.sink    rx,
  ssidip_res_if.source res
);

  ssidip_pkg::stage_t stage;
  logic               take;

  // Input register.
  ssidip_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx      (rx),
    .take_i  (take),
    .stage_o (stage)
  );

  // Field detection and result register.
  ssidip_extract #(
    .SsidLen   (SsidLen),
    .IpPartLen (IpPartLen)
  ) u_extract (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .take_o  (take),
    .res     (res)
  );

endmodule
